FILE: hw/rtl/mrp_pkg.sv
// ----------------------------------------------------------------------------
// MQTT receive parser package
// Shared types, packet type codes and status codes for the receive parser.
// ----------------------------------------------------------------------------
package mrp_pkg;

  // A continuation bit on this length byte ends the packet with an overflow.
  localparam int unsigned LEN_BYTES_MAX = 4;

  localparam int unsigned RC_W = 28;

  // Control packet types (upper nibble of the fixed header).
  localparam logic [3:0] PKT_CONNACK  = 4'd2;
  localparam logic [3:0] PKT_PUBLISH  = 4'd3;
  localparam logic [3:0] PKT_PUBACK   = 4'd4;
  localparam logic [3:0] PKT_PUBREC   = 4'd5;
  localparam logic [3:0] PKT_PUBREL   = 4'd6;
  localparam logic [3:0] PKT_PUBCOMP  = 4'd7;
  localparam logic [3:0] PKT_SUBACK   = 4'd9;
  localparam logic [3:0] PKT_UNSUBACK = 4'd11;
  localparam logic [3:0] PKT_PINGRESP = 4'd13;

  // Packet end status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TRUNC     = 3'd1;
  localparam logic [2:0] ST_REFUSED   = 3'd2;
  localparam logic [2:0] ST_UNKNOWN   = 3'd3;
  localparam logic [2:0] ST_OVERFLOW  = 3'd4;

  typedef enum logic [6:0] {
    PH_HEAD    = 7'b0000001,
    PH_LEN     = 7'b0000010,
    PH_TLEN    = 7'b0000100,
    PH_TOPIC   = 7'b0001000,
    PH_MID     = 7'b0010000,
    PH_PAYLOAD = 7'b0100000,
    PH_BODY    = 7'b1000000
  } phase_e;

  // One result per received byte.
  typedef struct packed {
    logic        data_valid;
    logic        data_is_payload;
    logic [7:0]  data_byte;
    logic        packet_end;
    logic [3:0]  packet_type;
    logic [2:0]  status;
    logic        ack_valid;
    logic [3:0]  ack_type;
    logic [15:0] ack_id;
    logic [7:0]  return_code;
    logic        connected;
    logic        keepalive_restart;
  } res_t;

endpackage

FILE: hw/rtl/mqtt_receive_parser_top.sv
// ----------------------------------------------------------------------------
// MQTT receive parser
// Parses a received MQTT 3.1.1 byte stream and gives one result per byte.
//
//   Channel  Dir  Handshake               Payload
//   s_axis   in   tvalid/tready           tdata[7:0] rx_byte
//   m_axis   out  tvalid/tready           tdata, tlast packet_end, tuser payload flag
//
// Each byte passes from the input register through the step logic into the
// result register. One byte is accepted per cycle when the output side keeps
// up. A stalled output holds the result register and the input register fills,
// then s_axis_tready_o drops.
// Reset is asynchronous; afterwards the parser expects a fixed header byte.
// ----------------------------------------------------------------------------
module mqtt_receive_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] data_valid, [8:1] data_byte, [12:9] packet_type, [15:13] status,
  // [16] ack_valid, [20:17] ack_type, [36:21] ack_id, [44:37] return_code,
  // [45] connected, [46] keepalive_restart, [47] zero
  output logic [47:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,   // packet_end
  output logic        m_axis_tuser_o    // [0] data_is_payload
);

  logic          in_vld_q, in_vld_d;
  logic [7:0]    in_byte_q;
  logic          step;
  logic          out_free;
  logic          in_acc;
  mrp_pkg::res_t step_res;
  mrp_pkg::res_t out_res;

  assign step            = in_vld_q && out_free;
  assign s_axis_tready_o = !in_vld_q || step;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign in_vld_d        = in_acc || (in_vld_q && !step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  mrp_parse_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .res_o  (step_res)
  );

  mrp_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step),
    .res_i   (step_res),
    .ready_i (m_axis_tready_i),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid_o),
    .res_o   (out_res)
  );

  assign m_axis_tdata_o = {1'b0,
                           out_res.keepalive_restart,
                           out_res.connected,
                           out_res.return_code,
                           out_res.ack_id,
                           out_res.ack_type,
                           out_res.ack_valid,
                           out_res.status,
                           out_res.packet_type,
                           out_res.data_byte,
                           out_res.data_valid};
  assign m_axis_tlast_o = out_res.packet_end;
  assign m_axis_tuser_o = out_res.data_is_payload;

  // Acknowledgements and keep-alive restarts only come with a packet end.
  a_ack_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tdata_o[16] || m_axis_tdata_o[46])) |-> m_axis_tlast_o)
    else $error("acknowledgement or keep-alive without packet end");

  // A nonzero status is only reported at a packet end.
  a_status_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tdata_o[15:13] != mrp_pkg::ST_OK)) |-> m_axis_tlast_o)
    else $error("status reported outside a packet end");

  // Payload flag only rides on a passed-on data byte.
  a_user_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> m_axis_tdata_o[0])
    else $error("payload flag without data byte");

endmodule

FILE: hw/rtl/mrp_parse_core.sv
// ----------------------------------------------------------------------------
// MQTT receive parser core
// Parse state registers and the per-byte step logic that yields one result.
// ----------------------------------------------------------------------------
module mrp_parse_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [7:0]    byte_i,
  output mrp_pkg::res_t res_o
);

  mrp_pkg::phase_e                phase_q, phase_d;
  logic [7:0]                     tf_q, tf_d;
  logic [mrp_pkg::RC_W-1:0]       rc_q, rc_d;
  logic [1:0]                     idx_q, idx_d;
  logic [15:0]                    fc_q, fc_d;
  logic [15:0]                    mid_q, mid_d;
  logic                           sess_q, sess_d;

  logic [mrp_pkg::RC_W-1:0]       len_add;
  logic                           fin;
  logic                           qos;

  always_comb begin
    case (idx_q)
      2'd0:    len_add = {21'b0, byte_i[6:0]};
      2'd1:    len_add = {14'b0, byte_i[6:0], 7'b0};
      2'd2:    len_add = {7'b0, byte_i[6:0], 14'b0};
      default: len_add = {byte_i[6:0], 21'b0};
    endcase
  end

  assign qos = (tf_q[2:1] != 2'b00);

  always_comb begin
    phase_d = phase_q;
    tf_d    = tf_q;
    rc_d    = rc_q;
    idx_d   = idx_q;
    fc_d    = fc_q;
    mid_d   = mid_q;
    sess_d  = sess_q;
    fin     = 1'b0;
    res_o   = '0;

    unique case (phase_q)
      mrp_pkg::PH_LEN: begin
        rc_d = rc_q + len_add;
        if (byte_i[7]) begin
          if ((3'({1'b0, idx_q}) + 3'd1) >= 3'(mrp_pkg::LEN_BYTES_MAX)) begin
            res_o.packet_end = 1'b1;
            res_o.status     = mrp_pkg::ST_OVERFLOW;
            rc_d             = '0;
            phase_d          = mrp_pkg::PH_HEAD;
          end else begin
            idx_d = idx_q + 2'd1;
          end
        end else begin
          fc_d    = '0;
          mid_d   = '0;
          idx_d   = '0;
          phase_d = (tf_q[7:4] == mrp_pkg::PKT_PUBLISH) ? mrp_pkg::PH_TLEN
                                                         : mrp_pkg::PH_BODY;
          fin     = (rc_d == '0);
        end
      end
      mrp_pkg::PH_TLEN: begin
        rc_d = rc_q - 28'd1;
        fc_d = {fc_q[7:0], byte_i};
        if (idx_q == 2'd0) begin
          idx_d = 2'd1;
        end else if (fc_d == 16'd0) begin
          idx_d   = '0;
          phase_d = qos ? mrp_pkg::PH_MID : mrp_pkg::PH_PAYLOAD;
        end else begin
          phase_d = mrp_pkg::PH_TOPIC;
        end
        fin = (rc_d == '0);
      end
      mrp_pkg::PH_TOPIC: begin
        rc_d             = rc_q - 28'd1;
        res_o.data_valid = 1'b1;
        res_o.data_byte  = byte_i;
        fc_d             = fc_q - 16'd1;
        if (fc_d == 16'd0) begin
          idx_d   = '0;
          phase_d = qos ? mrp_pkg::PH_MID : mrp_pkg::PH_PAYLOAD;
        end
        fin = (rc_d == '0);
      end
      mrp_pkg::PH_MID: begin
        rc_d  = rc_q - 28'd1;
        mid_d = {mid_q[7:0], byte_i};
        if (idx_q == 2'd0) begin
          idx_d = 2'd1;
        end else begin
          phase_d = mrp_pkg::PH_PAYLOAD;
        end
        fin = (rc_d == '0);
      end
      mrp_pkg::PH_PAYLOAD: begin
        rc_d                  = rc_q - 28'd1;
        res_o.data_valid      = 1'b1;
        res_o.data_is_payload = 1'b1;
        res_o.data_byte       = byte_i;
        fin                   = (rc_d == '0);
      end
      mrp_pkg::PH_BODY: begin
        rc_d = rc_q - 28'd1;
        // Only the first two body bytes are kept; the byte count saturates.
        if (fc_q < 16'd2) begin
          mid_d = {mid_q[7:0], byte_i};
        end
        if (fc_q != 16'hFFFF) begin
          fc_d = fc_q + 16'd1;
        end
        fin = (rc_d == '0);
      end
      default: begin
        tf_d    = byte_i;
        rc_d    = '0;
        idx_d   = '0;
        fc_d    = '0;
        mid_d   = '0;
        phase_d = mrp_pkg::PH_LEN;
      end
    endcase

    // Packet end: judged on the state as left by this byte.
    if (fin) begin
      res_o.packet_end = 1'b1;
      unique case (tf_d[7:4]) inside
        mrp_pkg::PKT_CONNACK: begin
          if (fc_d < 16'd2) begin
            res_o.status = mrp_pkg::ST_TRUNC;
          end else begin
            res_o.return_code = mid_d[7:0];
            if (mid_d[7:0] != 8'd0) begin
              res_o.status = mrp_pkg::ST_REFUSED;
            end else begin
              sess_d                  = 1'b1;
              res_o.keepalive_restart = 1'b1;
            end
          end
        end
        mrp_pkg::PKT_PUBLISH: begin
          if (phase_d != mrp_pkg::PH_PAYLOAD) begin
            res_o.status = mrp_pkg::ST_TRUNC;
          end else if (qos) begin
            res_o.ack_valid = 1'b1;
            res_o.ack_type  = tf_d[1] ? mrp_pkg::PKT_PUBACK : mrp_pkg::PKT_PUBREC;
            res_o.ack_id    = mid_d;
          end
        end
        mrp_pkg::PKT_PUBREL: begin
          if (fc_d < 16'd2) begin
            res_o.status = mrp_pkg::ST_TRUNC;
          end else begin
            res_o.ack_valid = 1'b1;
            res_o.ack_type  = mrp_pkg::PKT_PUBCOMP;
            res_o.ack_id    = mid_d;
          end
        end
        mrp_pkg::PKT_PINGRESP: begin
          res_o.keepalive_restart = 1'b1;
        end
        mrp_pkg::PKT_PUBACK, mrp_pkg::PKT_PUBCOMP,
        mrp_pkg::PKT_SUBACK, mrp_pkg::PKT_UNSUBACK: begin
          res_o.status = mrp_pkg::ST_OK;
        end
        default: begin
          res_o.status = mrp_pkg::ST_UNKNOWN;
        end
      endcase
      phase_d = mrp_pkg::PH_HEAD;
    end

    res_o.packet_type = tf_d[7:4];
    res_o.connected   = sess_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mrp_pkg::PH_HEAD;
      tf_q    <= '0;
      rc_q    <= '0;
      idx_q   <= '0;
      fc_q    <= '0;
      mid_q   <= '0;
      sess_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      tf_q    <= tf_d;
      rc_q    <= rc_d;
      idx_q   <= idx_d;
      fc_q    <= fc_d;
      mid_q   <= mid_d;
      sess_q  <= sess_d;
    end
  end

  // Once connected, the session flag is never cleared.
  a_sess_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sess_q |=> sess_q)
    else $error("session flag dropped");

  // Other bodies start with a cleared byte index and never advance it.
  a_idx_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == mrp_pkg::PH_BODY) |-> (idx_q == 2'd0))
    else $error("byte index set inside a plain body");

endmodule

FILE: hw/rtl/mrp_out_stage.sv
// ----------------------------------------------------------------------------
// MQTT receive parser output stage
// Result register that holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module mrp_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  mrp_pkg::res_t res_i,
  input  logic          ready_i,
  output logic          free_o,
  output logic          valid_o,
  output mrp_pkg::res_t res_o
);

  logic          vld_q, vld_d;
  mrp_pkg::res_t res_q;

  // The register can take a new result when empty or when its content leaves now.
  assign free_o = !vld_q || ready_i;
  assign vld_d  = load_i || (vld_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = vld_q;
  assign res_o   = res_q;

endmodule

FILE: tb/mqtt_receive_parser_top_test.sv
// ----------------------------------------------------------------------------
// MQTT receive parser testbench
// Streams MQTT packets, well-formed and broken, into the parser byte by byte.
// A behavioral copy of the parser predicts one result per accepted byte, and
// every output transfer is checked field by field against the oldest one.
// ----------------------------------------------------------------------------
module mqtt_receive_parser_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_BYTES = 110;

  // Type codes that the parser does not handle.
  localparam logic [3:0] PKT_RESERVED_LO = 4'd0;
  localparam logic [3:0] PKT_CONNECT     = 4'd1;
  localparam logic [3:0] PKT_RESERVED_HI = 4'd15;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [47:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;

  mqtt_receive_parser_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser)
  );

  always #2 clk_i = ~clk_i;

  logic [7:0]    rx_stream_q[$];
  logic [7:0]    body_q[$];
  mrp_pkg::res_t expected_res_q[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int hold_cnt = 0;
  int gen_bytes = 0;
  int err_cnt = 0;
  int idle_cycles = 0;
  int n_in = 0;
  int n_ends = 0;
  int n_bad = 0;
  int n_acks = 0;
  int n_data = 0;

  // Parser state as the predictor tracks it.
  mrp_pkg::phase_e ph_q = mrp_pkg::PH_HEAD;
  logic [7:0]      hdr_q = 8'h00;
  logic [27:0]     remain_q = '0;
  logic [1:0]      len_idx_q = '0;
  logic [15:0]     fcount_q = '0;
  logic [15:0]     msg_id_q = '0;
  logic            session_q = 1'b0;

  task automatic after_topic();
    len_idx_q = '0;
    ph_q = (hdr_q[2:1] != 2'b00) ? mrp_pkg::PH_MID : mrp_pkg::PH_PAYLOAD;
  endtask

  task automatic close_packet(inout mrp_pkg::res_t r);
    logic [2:0] st;
    st = mrp_pkg::ST_OK;
    r.packet_end = 1'b1;
    case (hdr_q[7:4]) inside
      mrp_pkg::PKT_CONNACK: begin
        if (fcount_q < 16'd2) begin
          st = mrp_pkg::ST_TRUNC;
        end else begin
          r.return_code = msg_id_q[7:0];
          if (msg_id_q[7:0] != 8'h00) begin
            st = mrp_pkg::ST_REFUSED;
          end else begin
            session_q = 1'b1;
            r.keepalive_restart = 1'b1;
          end
        end
      end
      mrp_pkg::PKT_PUBLISH: begin
        if (ph_q != mrp_pkg::PH_PAYLOAD) begin
          st = mrp_pkg::ST_TRUNC;
        end else if (hdr_q[2:1] != 2'b00) begin
          // QoS 1 wins when both QoS bits are set.
          r.ack_valid = 1'b1;
          r.ack_type = hdr_q[1] ? mrp_pkg::PKT_PUBACK : mrp_pkg::PKT_PUBREC;
          r.ack_id = msg_id_q;
        end
      end
      mrp_pkg::PKT_PUBREL: begin
        if (fcount_q < 16'd2) begin
          st = mrp_pkg::ST_TRUNC;
        end else begin
          r.ack_valid = 1'b1;
          r.ack_type = mrp_pkg::PKT_PUBCOMP;
          r.ack_id = msg_id_q;
        end
      end
      mrp_pkg::PKT_PINGRESP: r.keepalive_restart = 1'b1;
      mrp_pkg::PKT_PUBACK, mrp_pkg::PKT_PUBCOMP,
      mrp_pkg::PKT_SUBACK, mrp_pkg::PKT_UNSUBACK: ;
      default: st = mrp_pkg::ST_UNKNOWN;
    endcase
    r.status = st;
    ph_q = mrp_pkg::PH_HEAD;
  endtask

  task automatic parse_rx_byte(input logic [7:0] b, output mrp_pkg::res_t r);
    r = '0;
    case (ph_q) inside
      mrp_pkg::PH_LEN: begin
        remain_q = remain_q + (28'(b[6:0]) << (7 * len_idx_q));
        if (b[7]) begin
          if (len_idx_q + 1 >= mrp_pkg::LEN_BYTES_MAX) begin
            r.packet_end = 1'b1;
            r.status = mrp_pkg::ST_OVERFLOW;
            remain_q = '0;
            ph_q = mrp_pkg::PH_HEAD;
          end else begin
            len_idx_q = len_idx_q + 2'd1;
          end
        end else begin
          fcount_q = '0;
          msg_id_q = '0;
          len_idx_q = '0;
          ph_q = (hdr_q[7:4] == mrp_pkg::PKT_PUBLISH) ? mrp_pkg::PH_TLEN : mrp_pkg::PH_BODY;
          if (remain_q == '0) close_packet(r);
        end
      end
      mrp_pkg::PH_TLEN, mrp_pkg::PH_TOPIC, mrp_pkg::PH_MID, mrp_pkg::PH_PAYLOAD,
      mrp_pkg::PH_BODY: begin
        remain_q = remain_q - 28'd1;
        case (ph_q)
          mrp_pkg::PH_TLEN: begin
            fcount_q = {fcount_q[7:0], b};
            if (len_idx_q == 2'd0) begin
              len_idx_q = 2'd1;
            end else if (fcount_q == 16'd0) begin
              after_topic();
            end else begin
              ph_q = mrp_pkg::PH_TOPIC;
            end
          end
          mrp_pkg::PH_TOPIC: begin
            r.data_valid = 1'b1;
            r.data_byte = b;
            fcount_q = fcount_q - 16'd1;
            if (fcount_q == 16'd0) after_topic();
          end
          mrp_pkg::PH_MID: begin
            msg_id_q = {msg_id_q[7:0], b};
            if (len_idx_q == 2'd0) begin
              len_idx_q = 2'd1;
            end else begin
              ph_q = mrp_pkg::PH_PAYLOAD;
            end
          end
          mrp_pkg::PH_PAYLOAD: begin
            r.data_valid = 1'b1;
            r.data_is_payload = 1'b1;
            r.data_byte = b;
          end
          default: begin
            // Only the first two body bytes land in the id; the count saturates.
            if (fcount_q < 16'd2) msg_id_q = {msg_id_q[7:0], b};
            if (fcount_q != 16'hFFFF) fcount_q = fcount_q + 16'd1;
          end
        endcase
        if (remain_q == '0) close_packet(r);
      end
      default: begin
        hdr_q = b;
        remain_q = '0;
        len_idx_q = '0;
        fcount_q = '0;
        msg_id_q = '0;
        ph_q = mrp_pkg::PH_LEN;
      end
    endcase
    r.packet_type = hdr_q[7:4];
    r.connected = session_q;
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic push_rx(input logic [7:0] b);
    rx_stream_q.push_back(b);
    gen_bytes++;
  endtask

  task automatic add_random(input int n);
    int i;
    for (i = 0; i < n; i++) body_q.push_back(8'($urandom_range(255)));
  endtask

  // Header, remaining length over len_bytes bytes (0 picks a random legal
  // span, padding with zero groups), then the body.
  task automatic send_packet(input logic [7:0] hdr, input int len_bytes);
    int i;
    int n;
    int lo;
    logic [7:0] v;
    n = body_q.size();
    if (len_bytes == 0) begin
      lo = (n < 128) ? 1 : (n < 16384) ? 2 : 3;
      len_bytes = lo + $urandom_range(4 - lo);
    end
    push_rx(hdr);
    for (i = 0; i < len_bytes; i++) begin
      v = 8'((n >> (7 * i)) & 127);
      if (i < len_bytes - 1) v[7] = 1'b1;
      push_rx(v);
    end
    foreach (body_q[j]) push_rx(body_q[j]);
    body_q.delete();
  endtask

  task automatic build_publish(input logic [3:0] flags, input int topic_len,
                               input logic [15:0] mid, input int pay_len, input bit cut);
    int full;
    int keep;
    body_q.push_back(8'(topic_len >> 8));
    body_q.push_back(8'(topic_len));
    add_random(topic_len);
    if (flags[2:1] != 2'b00) begin
      body_q.push_back(mid[15:8]);
      body_q.push_back(mid[7:0]);
    end
    add_random(pay_len);
    if (cut) begin
      // End somewhere before the first payload byte.
      full = body_q.size();
      keep = $urandom_range(full - pay_len - 1);
      while (body_q.size() > keep) body_q.delete(body_q.size() - 1);
    end
    send_packet({mrp_pkg::PKT_PUBLISH, flags}, 0);
  endtask

  task automatic send_overflow(input logic [7:0] hdr);
    int i;
    push_rx(hdr);
    for (i = 0; i < mrp_pkg::LEN_BYTES_MAX; i++) push_rx(8'($urandom_range(255)) | 8'h80);
  endtask

  function automatic bit is_handled(input logic [3:0] t);
    return t inside {mrp_pkg::PKT_CONNACK, mrp_pkg::PKT_PUBLISH, mrp_pkg::PKT_PUBACK,
                     mrp_pkg::PKT_PUBREL, mrp_pkg::PKT_PUBCOMP, mrp_pkg::PKT_SUBACK,
                     mrp_pkg::PKT_UNSUBACK, mrp_pkg::PKT_PINGRESP};
  endfunction

  task automatic rand_packet();
    int pick;
    logic [3:0] t;
    pick = $urandom_range(99);
    if (pick < 58) begin
      build_publish(4'($urandom_range(15)), $urandom_range(8), 16'($urandom_range(65535)),
                    $urandom_range(12), pick >= 50);
    end else if (pick < 66) begin
      add_random($urandom_range(4));
      if (body_q.size() >= 2 && $urandom_range(9) < 6) body_q[1] = 8'h00;
      send_packet({mrp_pkg::PKT_CONNACK, 4'($urandom_range(15))}, 0);
    end else if (pick < 73) begin
      add_random($urandom_range(3));
      send_packet({mrp_pkg::PKT_PUBREL, 4'($urandom_range(15))}, 0);
    end else if (pick < 79) begin
      add_random($urandom_range(2));
      send_packet({mrp_pkg::PKT_PINGRESP, 4'($urandom_range(15))}, 0);
    end else if (pick < 88) begin
      case ($urandom_range(3))
        0: t = mrp_pkg::PKT_PUBACK;
        1: t = mrp_pkg::PKT_PUBCOMP;
        2: t = mrp_pkg::PKT_SUBACK;
        default: t = mrp_pkg::PKT_UNSUBACK;
      endcase
      add_random($urandom_range(4));
      send_packet({t, 4'($urandom_range(15))}, 0);
    end else if (pick < 95) begin
      do t = 4'($urandom_range(15)); while (is_handled(t));
      add_random($urandom_range(4));
      send_packet({t, 4'($urandom_range(15))}, 0);
    end else begin
      send_overflow(8'($urandom_range(255)));
    end
  endtask

  task automatic wait_drained();
    while (rx_stream_q.size() != 0 || s_tvalid || expected_res_q.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic random_phase(input int send_pct, input int recv_pct, input bit hold);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    hold_go = hold;
    gen_bytes = 0;
    while (gen_bytes < PHASE_BYTES) rand_packet();
    wait_drained();
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i) begin : driver
    mrp_pkg::res_t r;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        parse_rx_byte(s_tdata, r);
        expected_res_q.push_back(r);
        n_in++;
        if (r.packet_end) n_ends++;
        if (r.packet_end && r.status != mrp_pkg::ST_OK) n_bad++;
        if (r.ack_valid) n_acks++;
        if (r.data_valid) n_data++;
      end
      if (!s_tvalid || s_tready) begin
        if (rx_stream_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata <= rx_stream_q.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] seen);
    if (seen !== want) begin
      $error("%s: expected %0h, got %0h", name, want, seen);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin : monitor
    mrp_pkg::res_t want;
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_res_q.size() == 0) begin
          $error("result transfer with nothing expected: tdata %h", m_tdata);
          err_cnt++;
        end else begin
          want = expected_res_q.pop_front();
          check_field("data_valid", 16'(want.data_valid), 16'(m_tdata[0]));
          check_field("data_is_payload", 16'(want.data_is_payload), 16'(m_tuser));
          check_field("data_byte", 16'(want.data_byte), 16'(m_tdata[8:1]));
          check_field("packet_end", 16'(want.packet_end), 16'(m_tlast));
          check_field("packet_type", 16'(want.packet_type), 16'(m_tdata[12:9]));
          check_field("status", 16'(want.status), 16'(m_tdata[15:13]));
          check_field("ack_valid", 16'(want.ack_valid), 16'(m_tdata[16]));
          check_field("ack_type", 16'(want.ack_type), 16'(m_tdata[20:17]));
          check_field("ack_id", want.ack_id, m_tdata[36:21]);
          check_field("return_code", 16'(want.return_code), 16'(m_tdata[44:37]));
          check_field("connected", 16'(want.connected), 16'(m_tdata[45]));
          check_field("keepalive_restart", 16'(want.keepalive_restart), 16'(m_tdata[46]));
          check_field("tdata pad bit", 16'd0, 16'(m_tdata[47]));
        end
      end
      // One long hold lets the parser fill up and push back on its input.
      if (hold_go && !hold_done) begin
        m_tready <= 1'b0;
        hold_cnt++;
        if (hold_cnt >= HOLD_CYCLES) hold_done = 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("mqtt_receive_parser_top_test: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin : sequencer
    int i;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed packets, no idling.
    send_packet({mrp_pkg::PKT_PINGRESP, 4'h0}, 1);
    body_q = '{8'h00, 8'h05};
    send_packet({mrp_pkg::PKT_CONNACK, 4'h0}, 1);        // refused
    body_q = '{8'h01, 8'h00};
    send_packet({mrp_pkg::PKT_CONNACK, 4'h0}, 1);        // accepted
    body_q = '{8'hFF};
    send_packet({mrp_pkg::PKT_CONNACK, 4'hF}, 1);        // one byte short
    send_packet({mrp_pkg::PKT_CONNACK, 4'h0}, 4);        // empty, four length bytes
    body_q = '{8'h00, 8'h00, 8'hAA, 8'h55};
    send_packet({mrp_pkg::PKT_CONNACK, 4'h0}, 2);        // extra bytes ignored
    build_publish(4'h0, 3, 16'h0000, 4, 1'b0);
    build_publish(4'h2, 1, 16'hFFFF, 2, 1'b0);
    build_publish(4'h4, 2, 16'h0000, 0, 1'b0);
    build_publish(4'h6, 0, 16'hA5C3, 3, 1'b0);           // both QoS bits set
    build_publish(4'h9, 0, 16'h0000, 0, 1'b0);           // empty topic and payload
    send_packet({mrp_pkg::PKT_PUBLISH, 4'h2}, 1);        // empty body
    body_q = '{8'h00};
    send_packet({mrp_pkg::PKT_PUBLISH, 4'h0}, 1);        // cut inside topic length
    body_q = '{8'hFF, 8'hFF, 8'h00, 8'hFF};
    send_packet({mrp_pkg::PKT_PUBLISH, 4'h0}, 1);        // cut inside topic
    body_q = '{8'h00, 8'h01, 8'h61, 8'h12};
    send_packet({mrp_pkg::PKT_PUBLISH, 4'h2}, 1);        // cut inside message id
    body_q = '{8'h12, 8'h34};
    send_packet({mrp_pkg::PKT_PUBREL, 4'h2}, 1);
    body_q = '{8'hFF, 8'hFF, 8'h01};
    send_packet({mrp_pkg::PKT_PUBREL, 4'h2}, 3);
    body_q = '{8'h77};
    send_packet({mrp_pkg::PKT_PUBREL, 4'h2}, 1);
    body_q = '{8'h00, 8'h07};
    send_packet({mrp_pkg::PKT_PUBACK, 4'h0}, 1);
    send_packet({mrp_pkg::PKT_PUBCOMP, 4'h0}, 1);
    add_random(5);
    send_packet({mrp_pkg::PKT_SUBACK, 4'h0}, 4);         // padded length field
    add_random(2);
    send_packet({mrp_pkg::PKT_UNSUBACK, 4'h0}, 1);
    send_packet({PKT_RESERVED_LO, 4'h0}, 1);
    add_random(3);
    send_packet({PKT_CONNECT, 4'h0}, 1);
    body_q = '{8'h00, 8'h01};
    send_packet({mrp_pkg::PKT_PUBREC, 4'h0}, 1);
    send_packet({PKT_RESERVED_HI, 4'hF}, 1);
    send_overflow({mrp_pkg::PKT_PUBLISH, 4'h0});
    push_rx({mrp_pkg::PKT_PINGRESP, 4'h0});
    for (i = 0; i < mrp_pkg::LEN_BYTES_MAX; i++) push_rx(8'h80);
    build_publish(4'h2, 20, 16'h1357, 180, 1'b0);         // length field of two to four bytes
    wait_drained();

    random_phase(0, 0, 1'b0);
    random_phase(54, 0, 1'b0);
    random_phase(0, 54, 1'b0);
    random_phase(10, 10, 1'b0);
    random_phase(0, 0, 1'b1);
    hold_go = 1'b0;

    repeat (8) @(posedge clk_i);
    $display("Covered %0d bytes: %0d packet ends (%0d not ok), %0d acks, %0d data bytes.",
             n_in, n_ends, n_bad, n_acks, n_data);
    $display("Idle mixes: none, sender, receiver, both, and a %0d-cycle output hold.",
             HOLD_CYCLES);
    if (err_cnt == 0) begin
      $display("mqtt_receive_parser_top_test: done, clean");
    end else begin
      $display("mqtt_receive_parser_top_test: done, errors");
    end
    $finish;
  end

endmodule
